// ----- hdl/spv_pkg.sv -----
// Shared types and constants of the sample playback voice.
// Channel payloads, command classification, configuration set and divider constants.
// No dependencies.
`default_nettype none

package spv_pkg;

    // Command codes of the input channel
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;
    localparam logic [1:0] CMD_RENDER = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_OUTPUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_TARGET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_SOURCE = 3'd7;

    localparam int SC_W = 17;

    // Unity pan gain
    localparam logic [13:0] PAN_UNITY = 14'd10000;

    // Exact reciprocal multipliers: ceil(2^shift / divisor)
    localparam logic [30:0] RECIP_PAN = 31'd1759218605;
    localparam int          PAN_SHIFT = 44;
    localparam logic [23:0] RECIP_VOL = 24'd8454661;
    localparam int          VOL_SHIFT = 30;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        address;
        logic signed [15:0] data;
    } spv_in_t;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               is_playing;
    } spv_out_t;

    typedef struct packed {
        logic               filter_mode;
        logic               stereo_output;
        logic signed [14:0] pan;
        logic [6:0]         volume_target;
        logic [17:0]        pitch_step;
        logic [SC_W-1:0]    sample_count;
        logic               loop_enable;
        logic               stereo_source;
    } cfg_t;

    // Classified operation handed from the front to the back
    typedef struct packed {
        logic               do_write;
        logic               do_start;
        logic               do_stop;
        logic               do_render;
        logic [15:0]        address;
        logic signed [15:0] data;
    } spv_op_t;

    typedef struct packed {
        logic idle;
    } spv_stat_t;

endpackage

`default_nettype wire

// ----- hdl/spv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/spv_mod.sv -----
// Iterative remainder unit: one numerator bit per cycle, restoring form.
// Depends on nothing outside this file.
`default_nettype none

module spv_mod #(
    parameter int NW = 17,
    parameter int DW = 17
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               busy,
    output logic      [DW-1:0] rem
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    num_reg;
    logic [DW-1:0]    den_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW:0]      trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NW);
        end else if (busy_reg) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= fits ? DW'(trial - {1'b0, den_reg}) : DW'(trial);
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ----- hdl/spv_front.sv -----
// Input side: accepts words, classifies the command, holds them in a two-entry queue.
// Depends on spv_pkg.
`default_nettype none

module spv_front
    import spv_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire spv_in_t s_data,
    output logic         q_valid,
    output spv_op_t      q_op,
    input  wire logic    q_pop
);

    localparam int QD = 2;

    spv_op_t     entry_reg [QD];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    spv_op_t     op_c;

    always_comb begin
        op_c           = '0;
        op_c.address   = s_data.address;
        op_c.data      = s_data.data;
        case (s_data.cmd)
            CMD_WRITE:  op_c.do_write  = 1'b1;
            CMD_START:  op_c.do_start  = 1'b1;
            CMD_STOP:   op_c.do_stop   = 1'b1;
            CMD_RENDER: op_c.do_render = 1'b1;
            default:    op_c.do_render = 1'b1;
        endcase
    end

    assign s_ready = count_reg != 2'(QD);
    assign push    = s_valid && s_ready;
    assign q_valid = count_reg != 2'd0;
    assign q_op    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= op_c;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/spv_back.sv -----
// Execution side: sample store, voice state, render sequencer and output register.
// Depends on spv_pkg, spv_ram and spv_mod.
`default_nettype none

module spv_back
    import spv_pkg::*;
#(
    parameter int STORE_WORDS = 65536,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire cfg_t    cfg,
    input  wire logic    q_valid,
    input  wire spv_op_t q_op,
    output logic         q_pop,
    output logic         m_valid,
    input  wire logic    m_ready,
    output spv_out_t     m_data,
    output spv_stat_t    stat
);

    localparam int AW   = $clog2(STORE_WORDS);
    localparam int IW   = 32 - FRAC_BITS;
    localparam int NW   = IW + 1;
    localparam int MW   = ((NW > SC_W) ? NW : SC_W) + 1;
    localparam int XW0  = (AW > IW + 2) ? AW : IW + 2;
    localparam int XW   = (XW0 > MW) ? XW0 : MW;
    localparam int CW   = (SC_W + FRAC_BITS > 33) ? SC_W + FRAC_BITS : 33;
    localparam int IPW  = 17 + FRAC_BITS + 1;
    localparam int NUMW = IPW + 1;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] ST_WA     = 4'd1;
    localparam logic [ST_W-1:0] ST_MOD    = 4'd2;
    localparam logic [ST_W-1:0] ST_WB     = 4'd3;
    localparam logic [ST_W-1:0] ST_INTERP = 4'd4;
    localparam logic [ST_W-1:0] ST_SUM    = 4'd5;
    localparam logic [ST_W-1:0] ST_PAN    = 4'd6;
    localparam logic [ST_W-1:0] ST_DIV1   = 4'd7;
    localparam logic [ST_W-1:0] ST_VOL    = 4'd8;
    localparam logic [ST_W-1:0] ST_DIV2   = 4'd9;
    localparam logic [ST_W-1:0] ST_OUT    = 4'd10;

    function automatic logic [15:0] mag16(input logic [15:0] v);
        logic [15:0] m;
        m = v[15] ? (~v + 16'd1) : v;
        return m;
    endfunction

    // control state
    logic [ST_W-1:0] state_reg, state_next;
    logic            play_reg, play_next;
    logic [31:0]     pos_reg, pos_next;
    logic [6:0]      vol_reg, vol_next;
    logic            need_b_reg, need_b_next;
    logic            use_mod_reg, use_mod_next;
    logic            m_valid_reg, m_valid_next;

    // datapath
    logic [FRAC_BITS-1:0]  frac_reg;
    logic [AW-1:0]         b_addr_reg;
    logic [13:0]           lp_reg, rp_reg;
    logic signed [15:0]    a_reg, b_reg, s_reg;
    logic signed [IPW-1:0] iprod_reg;
    logic                  neg_l_reg, neg_r_reg;
    logic [29:0]           pm_l_reg, pm_r_reg;
    logic [15:0]           q_l_reg, q_r_reg;
    logic [22:0]           v_l_reg, v_r_reg;
    logic [15:0]           r_l_reg, r_r_reg;
    spv_out_t              m_data_reg;

    logic                  out_free, active, dispatch, load_silent, load_frame;
    logic                  ram_we, ram_re, mod_start, mod_busy;
    logic [AW-1:0]         ram_raddr, waddr_c, a_addr_c, b_addr_c, rem_addr_c;
    logic [15:0]           ram_rdata;
    logic [SC_W-1:0]       mod_rem;
    logic [IW-1:0]         idx_c;
    logic [NW-1:0]         nxt_c;
    logic [MW-1:0]         nxt_w, sc_w, wrap_w;
    logic                  fast1, fast2;
    logic [XW-1:0]         w_x, a_x, b_x, rem_x;
    logic [CW-1:0]         next_pos_w, end_w;
    logic [SC_W-1:0]       end_cnt;
    logic                  pan_neg;
    logic [14:0]           pan_mag;
    logic [13:0]           gain_att, lp_c, rp_c;
    logic signed [IPW-1:0] diff_x, frac_x;
    logic signed [NUMW-1:0] a_num, num_c, sh_c;
    logic                  adj_c;
    logic signed [15:0]    interp_s;
    logic [15:0]           s_mag;
    logic [60:0]           d1_l, d1_r;
    logic [46:0]           d2_l, d2_r;

    assign active   = play_reg && (cfg.sample_count != '0);
    assign out_free = !m_valid_reg || m_ready;

    // store addressing, modulo a power-of-two depth
    assign idx_c   = pos_reg[31:FRAC_BITS];
    assign nxt_c   = NW'(idx_c) + NW'(1);
    assign nxt_w   = MW'(nxt_c);
    assign sc_w    = MW'(cfg.sample_count);
    assign wrap_w  = nxt_w - sc_w;
    assign fast1   = nxt_w < sc_w;
    assign fast2   = wrap_w < sc_w;

    assign w_x     = XW'(q_op.address);
    assign waddr_c = w_x[AW-1:0];
    assign a_x     = cfg.stereo_source ? XW'({idx_c, 1'b0}) : XW'(idx_c);
    assign a_addr_c = a_x[AW-1:0];
    assign b_x     = cfg.stereo_source ? XW'({idx_c, 1'b1})
                                       : XW'(fast1 ? nxt_w : wrap_w);
    assign b_addr_c = b_x[AW-1:0];
    assign rem_x   = XW'(mod_rem);
    assign rem_addr_c = rem_x[AW-1:0];

    // end of sample test
    assign next_pos_w = CW'(pos_reg) + CW'(cfg.pitch_step);
    assign end_cnt    = cfg.stereo_source ? (cfg.sample_count >> 1) : cfg.sample_count;
    assign end_w      = CW'(end_cnt) << FRAC_BITS;

    // pan gains
    assign pan_neg  = cfg.pan[14];
    assign pan_mag  = pan_neg ? (~cfg.pan + 15'd1) : cfg.pan;
    assign gain_att = (pan_mag > {1'b0, PAN_UNITY}) ? 14'd0
                                                    : 14'({1'b0, PAN_UNITY} - pan_mag);
    assign lp_c = (cfg.stereo_output && !pan_neg && pan_mag != '0) ? gain_att : PAN_UNITY;
    assign rp_c = (cfg.stereo_output && pan_neg) ? gain_att : PAN_UNITY;

    // interpolation, truncated toward zero
    assign diff_x   = IPW'(b_reg) - IPW'(a_reg);
    assign frac_x   = IPW'($signed({1'b0, frac_reg}));
    assign a_num    = NUMW'(a_reg);
    assign num_c    = (a_num <<< FRAC_BITS) + NUMW'(iprod_reg);
    assign sh_c     = num_c >>> FRAC_BITS;
    assign adj_c    = num_c[NUMW-1] && (num_c[FRAC_BITS-1:0] != '0);
    assign interp_s = 16'(sh_c + NUMW'(adj_c));
    assign s_mag    = mag16(s_reg);

    assign d1_l = 61'(pm_l_reg) * 61'(RECIP_PAN);
    assign d1_r = 61'(pm_r_reg) * 61'(RECIP_PAN);
    assign d2_l = 47'(v_l_reg) * 47'(RECIP_VOL);
    assign d2_r = 47'(v_r_reg) * 47'(RECIP_VOL);

    always_comb begin
        state_next   = state_reg;
        play_next    = play_reg;
        pos_next     = pos_reg;
        vol_next     = vol_reg;
        need_b_next  = need_b_reg;
        use_mod_next = use_mod_reg;
        m_valid_next = m_valid_reg && !m_ready;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = a_addr_c;
        mod_start    = 1'b0;
        dispatch     = 1'b0;
        load_silent  = 1'b0;
        load_frame   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_op.do_write) begin
                        ram_we = 1'b1;
                        q_pop  = 1'b1;
                    end else if (q_op.do_start) begin
                        pos_next  = '0;
                        play_next = 1'b1;
                        q_pop     = 1'b1;
                    end else if (q_op.do_stop) begin
                        play_next = 1'b0;
                        q_pop     = 1'b1;
                    end else if (q_op.do_render && !active) begin
                        if (out_free) begin
                            q_pop        = 1'b1;
                            m_valid_next = 1'b1;
                            load_silent  = 1'b1;
                        end
                    end else if (q_op.do_render) begin
                        q_pop    = 1'b1;
                        dispatch = 1'b1;
                        ram_re   = 1'b1;
                        if (vol_reg < cfg.volume_target) begin
                            vol_next = vol_reg + 7'd1;
                        end else if (vol_reg > cfg.volume_target) begin
                            vol_next = vol_reg - 7'd1;
                        end
                        if (next_pos_w >= end_w) begin
                            pos_next = '0;
                            if (!cfg.loop_enable) begin
                                play_next = 1'b0;
                            end
                        end else begin
                            pos_next = next_pos_w[31:0];
                        end
                        need_b_next  = cfg.stereo_source || cfg.filter_mode;
                        use_mod_next = !cfg.stereo_source && cfg.filter_mode && !fast1 && !fast2;
                        mod_start    = use_mod_next;
                        state_next   = ST_WA;
                    end else begin
                        q_pop = 1'b1;
                    end
                end
            end
            ST_WA: begin
                if (!need_b_reg) begin
                    state_next = ST_INTERP;
                end else if (use_mod_reg) begin
                    state_next = ST_MOD;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = b_addr_reg;
                    state_next = ST_WB;
                end
            end
            ST_MOD: begin
                if (!mod_busy) begin
                    ram_re     = 1'b1;
                    ram_raddr  = rem_addr_c;
                    state_next = ST_WB;
                end
            end
            ST_WB:     state_next = ST_INTERP;
            ST_INTERP: state_next = ST_SUM;
            ST_SUM:    state_next = ST_PAN;
            ST_PAN:    state_next = cfg.stereo_source ? ST_VOL : ST_DIV1;
            ST_DIV1:   state_next = ST_VOL;
            ST_VOL:    state_next = ST_DIV2;
            ST_DIV2:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    load_frame   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            play_reg    <= 1'b0;
            pos_reg     <= '0;
            vol_reg     <= '0;
            need_b_reg  <= 1'b0;
            use_mod_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            play_reg    <= play_next;
            pos_reg     <= pos_next;
            vol_reg     <= vol_next;
            need_b_reg  <= need_b_next;
            use_mod_reg <= use_mod_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dispatch) begin
            frac_reg   <= pos_reg[FRAC_BITS-1:0];
            b_addr_reg <= b_addr_c;
            lp_reg     <= lp_c;
            rp_reg     <= rp_c;
        end
        if (state_reg == ST_WA) begin
            a_reg <= ram_rdata;
        end
        if (state_reg == ST_WB) begin
            b_reg <= ram_rdata;
        end
        if (state_reg == ST_INTERP) begin
            iprod_reg <= IPW'(diff_x * frac_x);
        end
        if (state_reg == ST_SUM) begin
            s_reg <= (cfg.filter_mode && !cfg.stereo_source) ? interp_s : a_reg;
        end
        if (state_reg == ST_PAN) begin
            if (cfg.stereo_source) begin
                neg_l_reg <= a_reg[15];
                neg_r_reg <= b_reg[15];
                q_l_reg   <= mag16(a_reg);
                q_r_reg   <= mag16(b_reg);
            end else begin
                neg_l_reg <= s_reg[15];
                neg_r_reg <= s_reg[15];
                pm_l_reg  <= 30'(s_mag) * 30'(lp_reg);
                pm_r_reg  <= 30'(s_mag) * 30'(rp_reg);
            end
        end
        if (state_reg == ST_DIV1) begin
            q_l_reg <= 16'(d1_l >> PAN_SHIFT);
            q_r_reg <= 16'(d1_r >> PAN_SHIFT);
        end
        if (state_reg == ST_VOL) begin
            v_l_reg <= 23'(q_l_reg) * 23'(vol_reg);
            v_r_reg <= 23'(q_r_reg) * 23'(vol_reg);
        end
        if (state_reg == ST_DIV2) begin
            r_l_reg <= 16'(d2_l >> VOL_SHIFT);
            r_r_reg <= 16'(d2_r >> VOL_SHIFT);
        end
        if (load_silent) begin
            m_data_reg.left_sample  <= '0;
            m_data_reg.right_sample <= '0;
            m_data_reg.is_playing   <= play_reg;
        end else if (load_frame) begin
            m_data_reg.left_sample  <= neg_l_reg ? (16'd0 - r_l_reg) : r_l_reg;
            m_data_reg.right_sample <= neg_r_reg ? (16'd0 - r_r_reg) : r_r_reg;
            m_data_reg.is_playing   <= play_reg;
        end
    end

    spv_ram #(
        .WIDTH (16),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr_c),
        .wdata (q_op.data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    spv_mod #(
        .NW (NW),
        .DW (SC_W)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .num     (nxt_c),
        .den     (cfg.sample_count),
        .busy    (mod_busy),
        .rem     (mod_rem)
    );

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign stat.idle = state_reg == ST_IDLE;

endmodule

`default_nettype wire

// ----- hdl/sample_playback_voice.sv -----
// Top level of the sample playback voice: configuration registers, front and back halves.
// Depends on spv_pkg, spv_front, spv_back (which holds spv_ram and spv_mod).
//
// Usage:
//   s_* channel (valid/ready) carries one command word: write a sample word,
//   start from position zero, stop, or render one frame. Only render words
//   produce a word on the m_* channel (left, right, is_playing).
//   cfg_wr_en/cfg_index/cfg_wdata write one register per cycle; write only
//   while the voice is idle.
// Timing:
//   A two-entry queue decouples the input from execution, so s_ready stays
//   high while a finished frame waits on m_ready, until the queue is full.
//   Write, start, stop and silent render are handled in the idle state of the back half.
//   An active render reads the store once per sample word it needs, then
//   passes one multiplier stage each for interpolation, pan, pan divide,
//   volume and volume divide; stereo sources skip the pan divide.
//   Interpolating past a shrunken sample also waits on the serial remainder unit.
// Reset: aresetn (synchronous) stops playback, clears position and volume
//   and loads register defaults; the sample store keeps its contents.
// Stall: a frame holds in the output register until m_ready; the next
//   render waits behind it, and commands queued after that render wait too.
// STORE_WORDS must be a power of two.
`default_nettype none

module sample_playback_voice
    import spv_pkg::*;
#(
    parameter int STORE_WORDS = 65536,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire spv_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output spv_out_t                   m_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t      cfg_reg, cfg_next;
    logic      q_valid;
    spv_op_t   q_op;
    logic      q_pop;
    spv_stat_t bk_stat;

    // Register file: decode the index, take only the field's bits
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FILTER_MODE:   cfg_next.filter_mode   = cfg_wdata[0];
                CFG_STEREO_OUTPUT: cfg_next.stereo_output = cfg_wdata[0];
                CFG_PAN:           cfg_next.pan           = $signed(cfg_wdata[14:0]);
                CFG_VOLUME_TARGET: cfg_next.volume_target = cfg_wdata[6:0];
                CFG_PITCH_STEP:    cfg_next.pitch_step    = cfg_wdata[17:0];
                CFG_SAMPLE_COUNT:  cfg_next.sample_count  = cfg_wdata[SC_W-1:0];
                CFG_LOOP_ENABLE:   cfg_next.loop_enable   = cfg_wdata[0];
                CFG_STEREO_SOURCE: cfg_next.stereo_source = cfg_wdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Load defaults: pan applied, unity pitch, full target volume, empty sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_mode   <= 1'b0;
            cfg_reg.stereo_output <= 1'b1;
            cfg_reg.pan           <= '0;
            cfg_reg.volume_target <= 7'd127;
            cfg_reg.pitch_step    <= 18'd65536;
            cfg_reg.sample_count  <= '0;
            cfg_reg.loop_enable   <= 1'b0;
            cfg_reg.stereo_source <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept and classify words, hold them until the back is free
    spv_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop)
    );

    // Execute one word at a time and drive the result register
    spv_back #(
        .STORE_WORDS (STORE_WORDS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .stat    (bk_stat)
    );

    // Pop only an occupied queue head
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // Take a new word only when the sequencer is idle
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> bk_stat.idle)
        else $error("queue popped while a render is in flight");

    // Drop any pending frame on reset
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
